// ===== sv/h2r_pkg.sv =====
// ---------------------------------------------------------------------------
// h2r_pkg
// Shared types and constants for the HSV to RGBA pixel converter.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package h2r_pkg;

   localparam int HUE_W   = 15;
   localparam int FRAC_W  = 9;
   localparam int PROD_W  = 17;   // val * sat, up to 65536
   localparam int WGT_W   = 12;   // sector weight, up to 3840
   localparam int SUM_W   = 28;   // channel numerator, up to 65536 * 3840
   localparam int CHAN_W  = 8;

   localparam logic [HUE_W-1:0]  HUE_FULL    = 15'd23040;
   localparam logic [HUE_W-1:0]  HUE_SECTOR  = 15'd3840;
   localparam logic [HUE_W-1:0]  HUE_PAIR    = 15'd7680;
   localparam logic [FRAC_W-1:0] Q_ONE       = 9'd256;

   // 255 / (65536 * 3840) == 17 / 2^24 exactly
   localparam logic [4:0]        SCALE_MUL   = 5'd17;
   localparam int                SCALE_SHIFT = 24;
   localparam logic [CHAN_W-1:0] CHAN_MAX    = 8'hFF;
   localparam logic [CHAN_W-1:0] ALPHA       = 8'hFF;

   // 60-degree hue sectors
   localparam logic [2:0] SECT_RED     = 3'd0;
   localparam logic [2:0] SECT_YELLOW  = 3'd1;
   localparam logic [2:0] SECT_GREEN   = 3'd2;
   localparam logic [2:0] SECT_CYAN    = 3'd3;
   localparam logic [2:0] SECT_BLUE    = 3'd4;
   localparam logic [2:0] SECT_MAGENTA = 3'd5;

   typedef struct packed {
      logic [2:0]        sector;
      logic [WGT_W-1:0]  weight;  // 3840 - |phase - 3840| in hue units
      logic [FRAC_W-1:0] sat;
      logic [FRAC_W-1:0] val;
   } front_type;

   typedef struct packed {
      logic [SUM_W-1:0] red;
      logic [SUM_W-1:0] green;
      logic [SUM_W-1:0] blue;
   } sum_type;

endpackage

// ===== sv/h2r_front.sv =====
// ---------------------------------------------------------------------------
// h2r_front
// Input stage: hue wrap, sat/val clamp, sector select and sector weight.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module h2r_front
   import h2r_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [HUE_W-1:0]  in_hue,
   input  logic [FRAC_W-1:0] in_sat,
   input  logic [FRAC_W-1:0] in_val,
   output logic              out_valid,
   output front_type         out_data
);

   logic             valid_ff;
   front_type        data_ff;
   front_type        data_in;
   logic [HUE_W-1:0] hue_w;
   logic [HUE_W-1:0] phase;

   always_comb begin
      hue_w = (in_hue >= HUE_FULL) ? (in_hue - HUE_FULL) : in_hue;

      if (hue_w >= 5 * HUE_SECTOR) begin
         data_in.sector = SECT_MAGENTA;
      end else if (hue_w >= 4 * HUE_SECTOR) begin
         data_in.sector = SECT_BLUE;
      end else if (hue_w >= 3 * HUE_SECTOR) begin
         data_in.sector = SECT_CYAN;
      end else if (hue_w >= 2 * HUE_SECTOR) begin
         data_in.sector = SECT_GREEN;
      end else if (hue_w >= HUE_SECTOR) begin
         data_in.sector = SECT_YELLOW;
      end else begin
         data_in.sector = SECT_RED;
      end

      // hue modulo two sectors
      if (hue_w >= 2 * HUE_PAIR) begin
         phase = HUE_W'(hue_w - 2 * HUE_PAIR);
      end else if (hue_w >= HUE_PAIR) begin
         phase = hue_w - HUE_PAIR;
      end else begin
         phase = hue_w;
      end

      if (phase >= HUE_SECTOR) begin
         data_in.weight = WGT_W'(HUE_PAIR - phase);
      end else begin
         data_in.weight = WGT_W'(phase);
      end

      data_in.sat = (in_sat > Q_ONE) ? Q_ONE : in_sat;
      data_in.val = (in_val > Q_ONE) ? Q_ONE : in_val;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== sv/h2r_chroma.sv =====
// ---------------------------------------------------------------------------
// h2r_chroma
// Three stages: chroma product, secondary product and offset, then
// per-channel numerators routed by sector.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module h2r_chroma
   import h2r_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      en,
   input  logic      in_valid,
   input  front_type in_data,
   output logic      out_valid,
   output sum_type   out_data
);

   // stage A: chroma
   logic              a_valid_ff;
   logic [PROD_W-1:0] a_chroma_ff;
   logic [FRAC_W-1:0] a_val_ff;
   logic [WGT_W-1:0]  a_weight_ff;
   logic [2:0]        a_sector_ff;
   logic [PROD_W-1:0] a_chroma_in;

   // stage B: secondary and offset
   logic              b_valid_ff;
   logic [SUM_W-1:0]  b_second_ff;
   logic [PROD_W-1:0] b_offset_ff;
   logic [PROD_W-1:0] b_chroma_ff;
   logic [2:0]        b_sector_ff;
   logic [SUM_W-1:0]  b_second_in;
   logic [PROD_W-1:0] b_offset_in;

   // stage C: routed numerators
   logic              c_valid_ff;
   sum_type           c_sum_ff;
   sum_type           c_sum_in;
   logic [SUM_W:0]    c_full;
   logic [SUM_W:0]    c_base;
   logic [SUM_W-1:0]  c_prim;
   logic [SUM_W-1:0]  c_off;

   assign a_chroma_in = PROD_W'(in_data.val * in_data.sat);

   assign b_second_in = SUM_W'(a_chroma_ff * a_weight_ff);
   assign b_offset_in = {a_val_ff, 8'b0} - a_chroma_ff;

   always_comb begin
      // x * 3840 == (x << 12) - (x << 8)
      c_full = {b_chroma_ff, 12'b0} - {4'b0, b_chroma_ff, 8'b0};
      c_base = {b_offset_ff, 12'b0} - {4'b0, b_offset_ff, 8'b0};
      c_prim = SUM_W'(c_full + c_base);
      c_off  = SUM_W'(c_base);
      c_sum_in.red   = c_off;
      c_sum_in.green = c_off;
      c_sum_in.blue  = c_off;
      case (b_sector_ff)
         SECT_RED: begin
            c_sum_in.red   = c_prim;
            c_sum_in.green = SUM_W'(b_second_ff + c_off);
         end
         SECT_YELLOW: begin
            c_sum_in.red   = SUM_W'(b_second_ff + c_off);
            c_sum_in.green = c_prim;
         end
         SECT_GREEN: begin
            c_sum_in.green = c_prim;
            c_sum_in.blue  = SUM_W'(b_second_ff + c_off);
         end
         SECT_CYAN: begin
            c_sum_in.green = SUM_W'(b_second_ff + c_off);
            c_sum_in.blue  = c_prim;
         end
         SECT_BLUE: begin
            c_sum_in.red   = SUM_W'(b_second_ff + c_off);
            c_sum_in.blue  = c_prim;
         end
         default: begin
            c_sum_in.red   = c_prim;
            c_sum_in.blue  = SUM_W'(b_second_ff + c_off);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_chroma_ff <= a_chroma_in;
         a_val_ff    <= in_data.val;
         a_weight_ff <= in_data.weight;
         a_sector_ff <= in_data.sector;
         b_second_ff <= b_second_in;
         b_offset_ff <= b_offset_in;
         b_chroma_ff <= a_chroma_ff;
         b_sector_ff <= a_sector_ff;
         c_sum_ff    <= c_sum_in;
      end
   end

   assign out_valid = c_valid_ff;
   assign out_data  = c_sum_ff;

endmodule

// ===== sv/h2r_scale.sv =====
// ---------------------------------------------------------------------------
// h2r_scale
// Scales one channel numerator to 0..255 with truncation and saturation.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module h2r_scale
   import h2r_pkg::*;
(
   input  logic              clock,
   input  logic              en,
   input  logic [SUM_W-1:0]  in_sum,
   output logic [CHAN_W-1:0] out_chan
);

   localparam int MUL_W = SUM_W + 5;

   logic [MUL_W-1:0]  scaled;
   logic [CHAN_W-1:0] chan_in;
   logic [CHAN_W-1:0] chan_ff;

   assign scaled  = MUL_W'(in_sum * SCALE_MUL);
   assign chan_in = (scaled[MUL_W-1:SCALE_SHIFT+CHAN_W] != '0) ? CHAN_MAX :
                    scaled[SCALE_SHIFT+CHAN_W-1:SCALE_SHIFT];

   always_ff @(posedge clock) begin
      if (en) begin
         chan_ff <= chan_in;
      end
   end

   assign out_chan = chan_ff;

endmodule

// ===== sv/hsv_to_rgb_pixel.sv =====
// Each pixel passes the front, chroma and scale stages to the result.
// One pixel per cycle unless stalled; five register stages advance together.
// A stall on the result side holds the whole pipeline; req_stall follows it.
// Reset clears all stage valid bits; no results are pending after reset.
// ---------------------------------------------------------------------------
// hsv_to_rgb_pixel
// HSV pixel to packed RGBA word converter, five-stage pipeline.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module hsv_to_rgb_pixel
   import h2r_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [HUE_W-1:0]  req_hue,
   input  logic [FRAC_W-1:0] req_sat,
   input  logic [FRAC_W-1:0] req_val,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [31:0]       rsp_pixel_word
);

   logic              en;
   logic              front_valid;
   front_type         front_data;
   logic              sum_valid;
   sum_type           sum_data;
   logic              out_valid_ff;
   logic [CHAN_W-1:0] red;
   logic [CHAN_W-1:0] green;
   logic [CHAN_W-1:0] blue;

   assign en        = !(out_valid_ff && rsp_stall);
   assign req_stall = !en;

   h2r_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .in_hue    (req_hue),
      .in_sat    (req_sat),
      .in_val    (req_val),
      .out_valid (front_valid),
      .out_data  (front_data)
   );

   h2r_chroma u_chroma (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (front_valid),
      .in_data   (front_data),
      .out_valid (sum_valid),
      .out_data  (sum_data)
   );

   h2r_scale u_scale_red (
      .clock    (clock),
      .en       (en),
      .in_sum   (sum_data.red),
      .out_chan (red)
   );

   h2r_scale u_scale_green (
      .clock    (clock),
      .en       (en),
      .in_sum   (sum_data.green),
      .out_chan (green)
   );

   h2r_scale u_scale_blue (
      .clock    (clock),
      .en       (en),
      .in_sum   (sum_data.blue),
      .out_chan (blue)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= sum_valid;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_pixel_word = {red, green, blue, ALPHA};

endmodule

// ===== tb/hsv_to_rgb_pixel_tb.sv =====
// ---------------------------------------------------------------------------
// hsv_to_rgb_pixel_tb
// Drives HSV pixels into the converter and checks every packed RGBA word
// against an exact integer conversion, under varying sender gaps and
// receiver stalls.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module hsv_to_rgb_pixel_tb
   import h2r_pkg::*;
();

   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 10;
   localparam int RANDOM_PER_PHASE = 138;
   localparam int NUM_PHASES = 4;

   // Expected pixel words in transaction order, plus the HSV conversion itself
   class pixel_scoreboard;
      logic [31:0] pixel_q[$];
      int errors;

      function new();
         errors = 0;
      endfunction

      // numerator is over 65536 * 3840; scale to 0..255 and truncate
      function longint unsigned to_channel(longint unsigned num);
         longint unsigned level;
         level = (num * 64'd255) / (64'd65536 * 64'd3840);
         return (level > 64'd255) ? 64'd255 : level;
      endfunction

      function logic [31:0] convert(logic [HUE_W-1:0] hue, logic [FRAC_W-1:0] sat,
                                    logic [FRAC_W-1:0] val);
         logic [HUE_W-1:0] h;
         logic [2:0] sect;
         longint unsigned s, v, phase, gap, chroma, cn, xn, mn, r, g, b;
         h = hue;
         if (h >= HUE_FULL) h = h - HUE_FULL;
         s = (sat > Q_ONE) ? 64'(Q_ONE) : 64'(sat);
         v = (val > Q_ONE) ? 64'(Q_ONE) : 64'(val);
         sect = 3'(h / HUE_SECTOR);
         phase = 64'(h % HUE_PAIR);
         gap = (phase >= 64'(HUE_SECTOR)) ? phase - 64'(HUE_SECTOR)
                                          : 64'(HUE_SECTOR) - phase;
         chroma = v * s;
         cn = chroma * 64'(HUE_SECTOR);
         xn = chroma * (64'(HUE_SECTOR) - gap);
         mn = (v * 64'(Q_ONE) - chroma) * 64'(HUE_SECTOR);
         case (sect)
            SECT_RED: begin
               r = cn; g = xn; b = 0;
            end
            SECT_YELLOW: begin
               r = xn; g = cn; b = 0;
            end
            SECT_GREEN: begin
               r = 0; g = cn; b = xn;
            end
            SECT_CYAN: begin
               r = 0; g = xn; b = cn;
            end
            SECT_BLUE: begin
               r = xn; g = 0; b = cn;
            end
            default: begin
               r = cn; g = 0; b = xn;
            end
         endcase
         return {8'(to_channel(r + mn)), 8'(to_channel(g + mn)),
                 8'(to_channel(b + mn)), ALPHA};
      endfunction

      function void note_pixel(logic [HUE_W-1:0] hue, logic [FRAC_W-1:0] sat,
                               logic [FRAC_W-1:0] val);
         pixel_q.push_back(convert(hue, sat, val));
      endfunction

      function void check_pixel(logic [31:0] got);
         logic [31:0] want;
         if (pixel_q.size() == 0) begin
            errors++;
            $display("%0t: pixel_word expected none, actual %h", $time, got);
            return;
         end
         want = pixel_q.pop_front();
         if (got !== want) begin
            errors++;
            $display("%0t: pixel_word expected %h, actual %h", $time, want, got);
         end
      endfunction

      function int pending();
         return pixel_q.size();
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [HUE_W-1:0]  req_hue = '0;
   logic [FRAC_W-1:0] req_sat = '0;
   logic [FRAC_W-1:0] req_val = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [31:0]       rsp_pixel_word;

   pixel_scoreboard sb = new();
   int idle_pct = 0;
   int stall_pct = 0;
   int cycle_count = 0;

   hsv_to_rgb_pixel dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_hue        (req_hue),
      .req_sat        (req_sat),
      .req_val        (req_val),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_pixel_word (rsp_pixel_word)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_pixel(rsp_pixel_word);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("hsv_to_rgb_pixel_tb failed");
         $finish;
      end
   end

   // One input transaction; returns at the edge where it is accepted
   task automatic send_pixel(logic [HUE_W-1:0] hue, logic [FRAC_W-1:0] sat,
                             logic [FRAC_W-1:0] val);
      while ((idle_pct > 0) && ($urandom_range(99) < idle_pct)) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_hue   <= hue;
      req_sat   <= sat;
      req_val   <= val;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_pixel(hue, sat, val);
   endtask

   task automatic wait_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic send_random_pixel();
      int roll;
      logic [HUE_W-1:0] hue;
      logic [FRAC_W-1:0] sat, val;
      roll = $urandom_range(99);
      if (roll < 10) begin
         hue = HUE_W'($urandom_range(32767, 23040));
      end else if (roll < 25) begin
         // land on or next to a sector boundary
         hue = HUE_W'($urandom_range(6) * 3840 + $urandom_range(2)) - 1'b1;
         if (hue > 15'd23039) hue = 15'd23039;
      end else begin
         hue = HUE_W'($urandom_range(23039));
      end
      roll = $urandom_range(99);
      if (roll < 10) sat = FRAC_W'($urandom_range(511, 257));
      else if (roll < 20) sat = (roll < 15) ? 9'd0 : Q_ONE;
      else sat = FRAC_W'($urandom_range(256));
      roll = $urandom_range(99);
      if (roll < 10) val = FRAC_W'($urandom_range(511, 257));
      else if (roll < 20) val = (roll < 15) ? 9'd0 : Q_ONE;
      else val = FRAC_W'($urandom_range(256));
      send_pixel(hue, sat, val);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: sector edges, hue wrap, saturated and zero sat/val
      send_pixel(15'd0,     9'd256, 9'd256);
      send_pixel(15'd1920,  9'd256, 9'd256);
      send_pixel(15'd3839,  9'd256, 9'd256);
      send_pixel(15'd3840,  9'd256, 9'd256);
      send_pixel(15'd7679,  9'd256, 9'd256);
      send_pixel(15'd7680,  9'd256, 9'd256);
      send_pixel(15'd11520, 9'd256, 9'd256);
      send_pixel(15'd15360, 9'd256, 9'd256);
      send_pixel(15'd19200, 9'd256, 9'd256);
      send_pixel(15'd23039, 9'd256, 9'd256);
      send_pixel(15'd23040, 9'd256, 9'd256);
      send_pixel(15'd32767, 9'd256, 9'd256);
      send_pixel(15'd5000,  9'd0,   9'd256);
      send_pixel(15'd5000,  9'd256, 9'd0);
      send_pixel(15'd0,     9'd0,   9'd0);
      send_pixel(15'd9000,  9'd511, 9'd511);
      send_pixel(15'd13000, 9'd257, 9'd200);
      send_pixel(15'd17000, 9'd128, 9'd257);
      send_pixel(15'd21000, 9'd1,   9'd1);
      send_pixel(15'd2000,  9'd255, 9'd255);
      send_pixel(15'd26000, 9'd300, 9'd100);
      send_pixel(15'd16383, 9'd170, 9'd85);
      wait_results();

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         case (phase)
            0: begin
               idle_pct = 0; stall_pct = 0;
            end
            1: begin
               idle_pct = 48; stall_pct = 0;
            end
            2: begin
               idle_pct = 0; stall_pct = 48;
            end
            default: begin
               idle_pct = 20; stall_pct = 20;
            end
         endcase
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            send_random_pixel();
            if ($urandom_range(63) == 0) wait_results();
         end
         wait_results();
      end

      stall_pct = 0;
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("hsv_to_rgb_pixel_tb passed");
      end else begin
         $display("hsv_to_rgb_pixel_tb failed");
      end
      $finish;
   end

endmodule
